### rtl/fss_pkg.sv
// Shared constants, codes and helper functions of the fuzzy subsequence scorer.
`timescale 1ns / 1ps

package fss_pkg;

  // Widths fixed by the register map and the stream fields.
  localparam int unsigned CharW      = 8;
  localparam int unsigned QLenW      = 6;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CharRegs   = 4;
  localparam int unsigned BytesPerReg = CfgDataW / CharW;
  localparam int unsigned QueryBytes = CharRegs * BytesPerReg;
  localparam int unsigned ScoreW     = 9;
  localparam int unsigned AddW       = 4;
  localparam int unsigned OutDataW   = 16;

  localparam logic [ScoreW-1:0] ScoreMax   = '1;
  localparam logic [AddW-1:0]   BonusBase  = 4'd1;
  localparam logic [AddW-1:0]   BonusRun   = 4'd3;
  localparam logic [AddW-1:0]   BonusWord  = 4'd5;

  // Characters that end a word, and the letter bounds and offset used for case folding.
  localparam logic [CharW-1:0] ChSpace      = 8'h20;
  localparam logic [CharW-1:0] ChUnderscore = 8'h5F;
  localparam logic [CharW-1:0] ChHyphen     = 8'h2D;
  localparam logic [CharW-1:0] ChUpperA     = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ     = 8'h5A;
  localparam logic [CharW-1:0] CaseOffset   = 8'h20;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_QUERY_LENGTH  = 3'd0,
    REG_QUERY_CHARS_0 = 3'd1,
    REG_QUERY_CHARS_1 = 3'd2,
    REG_QUERY_CHARS_2 = 3'd3,
    REG_QUERY_CHARS_3 = 3'd4
  } cfg_reg_e;

  // Folds ASCII upper-case letters to lower case, leaves all other bytes alone.
  function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

  function automatic logic is_separator(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c == ChUnderscore) || (c == ChHyphen);
  endfunction

endpackage

### rtl/fuzzy_subsequence_scorer_unit.sv
// Top level of the fuzzy subsequence scorer: query registers, input register, scan state and result register.
`timescale 1ns / 1ps
//
// Channel  | Direction | Payload                                   | Accepted when
// ---------+-----------+-------------------------------------------+-----------------------------
// s_axis   | in        | tdata[7:0] text_char, tlast end_of_text   | s_axis_tvalid & s_axis_tready
// m_axis   | out       | tdata[0] matched, tdata[9:1] match_score  | m_axis_tvalid & m_axis_tready
// cfg      | in        | cfg_index_i register, cfg_data_i value    | cfg_we_i high
//
// Every word lands in the input register, and the compare of its folded byte against the
// current query byte plus the score add happen in the next cycle, while the next word is
// already being taken. A single scan state register set (position, run, word start, score)
// lets the block take one word per cycle whenever the input does not stall. An end word
// waits in the input register until the result register is free, then loads it, and its
// result stays until the sink takes it. The input stalls only while an end word sits in the
// input register and an earlier result is still waiting on a stalled output.
// Reset clears the query registers and both valid flags and puts the scan state at its start.

module fuzzy_subsequence_scorer_unit
  import fss_pkg::*;
#(
  parameter int unsigned MAX_QUERY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // Text words.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,   // [7:0] text_char
  input  logic                s_axis_tlast,   // end_of_text

  // Results.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] matched, [9:1] match_score, rest zero

  // Register writes.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // The position counts up to MAX_QUERY; compares run at a width that also holds the
  // six-bit length register.
  localparam int unsigned PosW = $clog2(MAX_QUERY + 1);
  localparam int unsigned CmpW = (PosW > QLenW) ? PosW : QLenW;
  localparam logic [CmpW-1:0] MaxQ = CmpW'(MAX_QUERY);
  localparam int unsigned ByteIdxW = $clog2(QueryBytes);
  localparam logic [CmpW-1:0] QueryBytesC = CmpW'(QueryBytes);

  // ---------------------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------------------
  logic [QLenW-1:0]    qlen_q;
  logic [CfgDataW-1:0] qchars_q [CharRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q <= '0;
      for (int i = 0; i < CharRegs; i++) begin
        qchars_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_QUERY_LENGTH:  qlen_q      <= cfg_data_i[QLenW-1:0];
        REG_QUERY_CHARS_0: qchars_q[0] <= cfg_data_i;
        REG_QUERY_CHARS_1: qchars_q[1] <= cfg_data_i;
        REG_QUERY_CHARS_2: qchars_q[2] <= cfg_data_i;
        REG_QUERY_CHARS_3: qchars_q[3] <= cfg_data_i;
        default: ;  // Writes to unused indexes are dropped.
      endcase
    end
  end

  // Byte view of the query, byte 0 in the lowest bits of the first register.
  logic [CharW-1:0] qbyte [QueryBytes];
  for (genvar g = 0; g < QueryBytes; g++) begin : g_qbyte
    assign qbyte[g] = qchars_q[g / BytesPerReg][(g % BytesPerReg) * CharW +: CharW];
  end

  // ---------------------------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------------------------
  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] in_char_q;
  logic             in_end_q;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             advance;

  // The result register can take a new result when it is empty or being drained.
  assign out_free = !out_valid_q || m_axis_tready;
  // A text word always moves on; an end word needs room for its result.
  assign advance  = in_valid_q && (!in_end_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Scan state and its update.
  // ---------------------------------------------------------------------------------------
  logic [PosW-1:0]   pos_q, pos_d;
  logic              run_q, run_d;
  logic              ws_q, ws_d;
  logic [ScoreW-1:0] score_q, score_d;

  logic [CmpW-1:0]     len_ext;
  logic [CmpW-1:0]     len_use;
  logic [CmpW-1:0]     pos_ext;
  logic                used_up;
  logic [CharW-1:0]    cur_qbyte;
  logic                hit;
  logic [AddW-1:0]     bonus;
  logic [ScoreW:0]     score_sum;

  assign len_ext = CmpW'(qlen_q);
  assign len_use = (len_ext > MaxQ) ? MaxQ : len_ext;
  assign pos_ext = CmpW'(pos_q);
  assign used_up = (pos_ext >= len_use);

  // Query bytes beyond the register file read as zero.
  assign cur_qbyte = (pos_ext < QueryBytesC) ? qbyte[pos_ext[ByteIdxW-1:0]] : '0;
  assign hit = (fold_case(in_char_q) == fold_case(cur_qbyte));

  assign bonus = BonusBase + (run_q ? BonusRun : '0) + (ws_q ? BonusWord : '0);
  assign score_sum = {1'b0, score_q} + (ScoreW + 1)'(bonus);

  always_comb begin
    pos_d   = pos_q;
    run_d   = run_q;
    ws_d    = ws_q;
    score_d = score_q;
    if (advance) begin
      if (in_end_q) begin
        // The end word closes the text and starts a fresh scan.
        pos_d   = '0;
        run_d   = 1'b0;
        ws_d    = 1'b1;
        score_d = '0;
      end else if (!used_up) begin
        if (hit) begin
          score_d = score_sum[ScoreW] ? ScoreMax : score_sum[ScoreW-1:0];
          run_d   = 1'b1;
          pos_d   = pos_q + PosW'(1);
        end else begin
          run_d   = 1'b0;
        end
        ws_d = is_separator(in_char_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      run_q   <= 1'b0;
      ws_q    <= 1'b1;
      score_q <= '0;
    end else begin
      pos_q   <= pos_d;
      run_q   <= run_d;
      ws_q    <= ws_d;
      score_q <= score_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------------------
  logic              out_matched_q;
  logic [ScoreW-1:0] out_score_q;
  logic              load_result;

  assign load_result = advance && in_end_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = load_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      out_matched_q <= used_up;
      out_score_q   <= used_up ? score_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - ScoreW - 1)'(0), out_score_q, out_matched_q};

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(pos_q) <= MaxQ)
    else $error("query position ran past the query limit");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> (pos_q == '0) && (score_q == '0) && ws_q && !run_q)
    else $error("scan state not restarted after an end word");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(load_result))
    else $error("result appeared without an end word");

  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_matched_q) |-> (out_score_q == '0))
    else $error("unmatched result carries a score");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !load_result)
    else $error("result overwritten while stalled");

endmodule

### dv/fss_score_checker.sv
// Scoreboard for the fuzzy subsequence scorer: predicts every result word and compares it.
`timescale 1ns / 1ps

module fss_score_checker
  import fss_pkg::*;
#(
  parameter int unsigned MAX_QUERY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  scores_seen_o,
  output int                  matches_seen_o
);

  typedef struct packed {
    logic              matched;
    logic [ScoreW-1:0] score;
  } score_word_t;

  score_word_t         expected_scores[$];
  logic [QLenW-1:0]    query_len_q;
  logic [CfgDataW-1:0] query_regs_q [CharRegs];
  int unsigned         scan_pos_q;
  logic                run_q;
  logic                word_start_q;
  logic [ScoreW-1:0]   score_q;

  function automatic logic [CharW-1:0] to_lower(input logic [CharW-1:0] c);
    return (c >= ChUpperA && c <= ChUpperZ) ? c + CaseOffset : c;
  endfunction

  // Query bytes past the last register read as zero.
  function automatic logic [CharW-1:0] query_char(input int unsigned idx);
    if (idx >= QueryBytes) return '0;
    return query_regs_q[idx / BytesPerReg][(idx % BytesPerReg) * CharW +: CharW];
  endfunction

  task automatic clear_scan();
    scan_pos_q   = 0;
    run_q        = 1'b0;
    word_start_q = 1'b1;
    score_q      = '0;
  endtask

  task automatic scan_word(input logic [CharW-1:0] ch, input logic last);
    score_word_t  res;
    int unsigned  limit;
    int unsigned  sum;
    limit = (query_len_q > MAX_QUERY) ? MAX_QUERY : query_len_q;
    if (last) begin
      res.matched = (scan_pos_q >= limit);
      res.score   = res.matched ? score_q : '0;
      expected_scores.push_back(res);
      clear_scan();
    end else if (scan_pos_q < limit) begin
      if (to_lower(ch) == to_lower(query_char(scan_pos_q))) begin
        sum = score_q + BonusBase + (run_q ? BonusRun : 0) + (word_start_q ? BonusWord : 0);
        score_q    = (sum > ScoreMax) ? ScoreMax : sum[ScoreW-1:0];
        run_q      = 1'b1;
        scan_pos_q = scan_pos_q + 1;
      end else begin
        run_q = 1'b0;
      end
      word_start_q = (ch == ChSpace) || (ch == ChUnderscore) || (ch == ChHyphen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    score_word_t got;
    score_word_t want;
    if (!rst_ni) begin
      expected_scores.delete();
      query_len_q = '0;
      foreach (query_regs_q[r]) query_regs_q[r] = '0;
      clear_scan();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.matched = m_axis_tdata[0];
        got.score   = m_axis_tdata[ScoreW:1];
        scores_seen_o++;
        if (expected_scores.size() == 0) begin
          $error("result word 0x%h arrived while no score was expected", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_scores.pop_front();
          if (got.matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, got.matched);
            fail_count_o++;
          end
          if (got.score !== want.score) begin
            $error("match_score: expected %0d, got %0d", want.score, got.score);
            fail_count_o++;
          end
          if (m_axis_tdata[OutDataW-1:ScoreW+1] !== '0) begin
            $error("tdata padding: expected 0, got 0x%h", m_axis_tdata[OutDataW-1:ScoreW+1]);
            fail_count_o++;
          end
          if (want.matched) matches_seen_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_QUERY_LENGTH: query_len_q = cfg_data_i[QLenW-1:0];
          REG_QUERY_CHARS_0, REG_QUERY_CHARS_1, REG_QUERY_CHARS_2, REG_QUERY_CHARS_3:
            query_regs_q[cfg_index_i - REG_QUERY_CHARS_0] = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) scan_word(s_axis_tdata, s_axis_tlast);
      pending_o = expected_scores.size();
    end
  end

endmodule

### dv/testbench.sv
// Top of the scorer testbench: clock, reset, text stimulus, result sink and the verdict.
`timescale 1ns / 1ps

module testbench;
  import fss_pkg::*;

  // Run sizing. The hold-off is long enough for two end words to pile up behind a stalled
  // result, which backs the block up into its input.
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned HOLD_CYCLES   = 160;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned LEN_FIELD_MAX = (1 << QLenW) - 1;

  typedef enum int unsigned {SINK_ALWAYS, SINK_COIN, SINK_SLOW} sink_mode_e;
  typedef enum int unsigned {TEXT_FULL, TEXT_PARTIAL, TEXT_NOISE} text_shape_e;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [CharW-1:0]    s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int scores_seen;
  int matches_seen;

  // Stimulus bookkeeping, used for the summary and to size the random part.
  int          text_words  = 0;
  int          end_words   = 0;
  int          query_loads = 0;
  int          hold_offs   = 0;
  int unsigned burst_left  = 0;
  bit          sender_steady = 1'b0;
  sink_mode_e  sink_mode     = SINK_ALWAYS;
  bit          hold_request  = 1'b0;

  // Mirror of the query that is loaded, so that texts can be built to match it.
  logic [CharW-1:0] query_bytes [QueryBytes];
  int unsigned      query_used;
  logic [CharW-1:0] text_q[$];

  fuzzy_subsequence_scorer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  fss_score_checker u_score_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .scores_seen_o  (scores_seen),
    .matches_seen_o (matches_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Safety net: a correct run needs a small fraction of this time.
  initial begin
    #5_000_000;
    $display("fuzzy_subsequence_scorer_unit test failed");
    $finish;
  end

  // Result sink. It follows its own pattern, and on request it holds tready low for a hold-off
  // that it counts itself, while the sender keeps offering words.
  initial begin : sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        case (sink_mode)
          SINK_ALWAYS: m_axis_tready = 1'b1;
          SINK_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
          default:     m_axis_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Mostly letters a to f in either case, so that texts hit the query often, plus the word
  // separators and now and then any byte value at all.
  function automatic logic [CharW-1:0] pick_char();
    int unsigned      roll;
    logic [CharW-1:0] c;
    roll = $urandom_range(0, 19);
    if (roll < 11) begin
      c = "a";
      c = c + CharW'($urandom_range(0, 5));
      if ($urandom_range(0, 1)) c = c - CaseOffset;
    end else if (roll < 14) begin
      case ($urandom_range(0, 2))
        0:       c = ChSpace;
        1:       c = ChUnderscore;
        default: c = ChHyphen;
      endcase
    end else begin
      c = CharW'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Swaps the case of a letter half of the time; other bytes pass unchanged.
  function automatic logic [CharW-1:0] flip_case(input logic [CharW-1:0] c);
    logic [CharW-1:0] lower_a;
    logic [CharW-1:0] lower_z;
    lower_a = "a";
    lower_z = "z";
    if (((c >= ChUpperA && c <= ChUpperZ) || (c >= lower_a && c <= lower_z)) &&
        $urandom_range(0, 1))
      return c ^ CaseOffset;
    return c;
  endfunction

  // Puts one word on the input. A new burst starts after a random gap unless the sender
  // runs steady; tvalid stays high from one word to the next within a burst.
  task automatic send_word(input logic [CharW-1:0] ch, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = ch;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left = burst_left - 1;
    if (last) end_words++;
    else text_words++;
  endtask

  // Lowers tvalid and waits until every expected score has come back, then lets a settle
  // period pass so that the last text words have also left the pipeline. Registers may then
  // be written safely, even when a text is still open.
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Writes the four character registers from the mirror, then the length word.
  task automatic write_query(input logic [CfgDataW-1:0] len_word);
    logic [CfgDataW-1:0] chunk;
    for (int r = 0; r < CharRegs; r++) begin
      for (int b = 0; b < BytesPerReg; b++)
        chunk[b*CharW +: CharW] = query_bytes[r*BytesPerReg + b];
      write_reg(CfgIdxW'(REG_QUERY_CHARS_0 + r), chunk);
    end
    write_reg(REG_QUERY_LENGTH, len_word);
    query_used = (len_word[QLenW-1:0] > QueryBytes) ? QueryBytes : len_word[QLenW-1:0];
    query_loads++;
  endtask

  task automatic load_query_string(input string s, input logic [CfgDataW-1:0] len_word);
    foreach (query_bytes[i]) query_bytes[i] = '0;
    for (int i = 0; i < s.len(); i++) query_bytes[i] = s[i];
    write_query(len_word);
  endtask

  // Random query. Short lengths dominate; the empty query, the full 32 bytes and lengths
  // beyond the limit show up too. Upper bits of the length word are often junk.
  task automatic pick_query();
    int unsigned         roll;
    logic [CfgDataW-1:0] len_word;
    roll     = $urandom_range(0, 19);
    len_word = {$urandom, $urandom};
    if (roll == 0)       len_word[QLenW-1:0] = '0;
    else if (roll < 14)  len_word[QLenW-1:0] = QLenW'($urandom_range(1, 6));
    else if (roll < 17)  len_word[QLenW-1:0] = QLenW'($urandom_range(7, QueryBytes - 1));
    else if (roll == 17) len_word[QLenW-1:0] = QLenW'(QueryBytes);
    else len_word[QLenW-1:0] = QLenW'($urandom_range(QueryBytes + 1, LEN_FIELD_MAX));
    if ($urandom_range(0, 1)) len_word[CfgDataW-1:QLenW] = '0;
    foreach (query_bytes[i]) query_bytes[i] = pick_char();
    write_query(len_word);
  endtask

  // Builds one text. A full text carries the whole query with random case and noise in
  // between; a partial one stops short; a noise text is random bytes only.
  task automatic send_text(input text_shape_e shape, input bit with_end,
                           input int unsigned noise_max);
    int unsigned stop;
    text_q.delete();
    stop = 0;
    if (shape == TEXT_FULL) stop = query_used;
    else if (shape == TEXT_PARTIAL && query_used > 0) stop = $urandom_range(0, query_used - 1);
    for (int i = 0; i < stop; i++) begin
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) text_q.push_back(pick_char());
      text_q.push_back(flip_case(query_bytes[i]));
    end
    repeat ($urandom_range(0, noise_max)) text_q.push_back(pick_char());
    foreach (text_q[i]) send_word(text_q[i], 1'b0);
    if (with_end) send_word(pick_char(), 1'b1);
  endtask

  task automatic send_string(input string s, input bit with_end);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
    if (with_end) send_word(pick_char(), 1'b1);
  endtask

  initial begin : stimulus
    int          directed_items;
    int          phase;
    int unsigned roll;
    int unsigned guard;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_QUERY_LENGTH;
    cfg_data_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. Right after reset the query is empty, so an end word alone must give
    // a match with a zero score.
    send_word(pick_char(), 1'b1);
    wait_drained();

    // Length one over the all-zero query bytes: a zero text byte is an ordinary character.
    write_reg(REG_QUERY_LENGTH, CfgDataW'(1));
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    wait_drained();

    // Case folding on both sides, a run bonus, and word starts after each separator.
    load_query_string("gO_x", CfgDataW'(4));
    send_string(" Go_-X", 1'b1);
    wait_drained();

    // The length shrinks in the middle of a text to what is already matched, so the end
    // word finds the query used up.
    send_string("gO", 1'b0);
    wait_drained();
    write_reg(REG_QUERY_LENGTH, CfgDataW'(2));
    send_word(ChUpperA, 1'b1);
    wait_drained();

    // Every bit of the length word set: the length in use is limited to the full query.
    write_reg(REG_QUERY_LENGTH, '1);
    send_word(8'h00, 1'b1);
    wait_drained();

    // A write to an index with no register behind it must change nothing.
    write_reg(CfgIdxW'(REG_QUERY_CHARS_3 + $urandom_range(1, 3)), {$urandom, $urandom});
    send_string("gOx", 1'b1);
    wait_drained();
    directed_items = text_words + end_words;

    // Random phases: a new query, new sender and sink behavior, a handful of texts. Some
    // phases leave a text open, so the next query takes effect mid-text.
    phase = 0;
    while (text_words + end_words < directed_items + RANDOM_ITEMS) begin
      pick_query();
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_mode     = sink_mode_e'($urandom_range(0, 2));
      if (phase % 10 == 3) begin
        // Short texts while the sink holds off: results back up and the input stalls.
        hold_request = 1'b1;
        hold_offs++;
        repeat (6) send_text(TEXT_NOISE, 1'b1, 2);
      end
      repeat ($urandom_range(3, 10)) begin
        roll = $urandom_range(0, 19);
        if (roll < 12)      send_text(TEXT_FULL, 1'b1, 4);
        else if (roll < 17) send_text(TEXT_PARTIAL, 1'b1, 4);
        else                send_text(TEXT_NOISE, 1'b1, 16);
      end
      if ($urandom_range(0, 3) == 0) send_text(TEXT_PARTIAL, 1'b0, 3);
      wait_drained();
      phase++;
    end

    // Final drain with the sink always ready, bounded so that a lost result shows up as
    // a leftover expectation rather than a hang.
    sink_mode = SINK_ALWAYS;
    s_axis_tvalid = 1'b0;
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
    if (pending != 0) $error("%0d expected scores never arrived", pending);

    $display("Run: %0d text words and %0d end words over %0d query loads, %0d hold-offs.",
             text_words, end_words, query_loads, hold_offs);
    $display("Scores checked: %0d, of which %0d full matches.", scores_seen, matches_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("fuzzy_subsequence_scorer_unit test passed");
    end else begin
      $display("fuzzy_subsequence_scorer_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/fss_pkg.sv
rtl/fuzzy_subsequence_scorer_unit.sv
dv/fss_score_checker.sv
dv/testbench.sv
